// ----- sv/gne_pkg.sv -----
// shared types and constants for the grid neighbour expander
// no dependencies; imported by the interfaces and every module but gne_ram
package gne_pkg;

  // configuration register indexes
  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;
  localparam int   CFG_W          = 9;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int NBR_COUNT = 8;
  localparam int IDX_W     = 16;

  // row and column position of a neighbour inside the 3x3 window
  localparam logic [1:0] ROW_DN  = 2'd0;
  localparam logic [1:0] ROW_CTR = 2'd1;
  localparam logic [1:0] ROW_UP  = 2'd2;
  localparam logic [1:0] COL_L   = 2'd0;
  localparam logic [1:0] COL_M   = 2'd1;
  localparam logic [1:0] COL_R   = 2'd2;

  // visiting order: +y, +x, -y, -x, then (-x,+y), (+x,+y), (+x,-y), (-x,-y)
  localparam logic [1:0] NBR_ROW [NBR_COUNT] = '{
    ROW_UP, ROW_CTR, ROW_DN, ROW_CTR, ROW_UP, ROW_UP, ROW_DN, ROW_DN
  };
  localparam logic [1:0] NBR_COL [NBR_COUNT] = '{
    COL_M, COL_R, COL_M, COL_L, COL_L, COL_R, COL_R, COL_L
  };

  // context handed from the sequencer to the result stage
  typedef struct packed {
    logic [NBR_COUNT-1:0] mask;
    logic [7:0]           cx;
    logic [IDX_W-1:0]     base_dn;
    logic [IDX_W-1:0]     base_ctr;
    logic [IDX_W-1:0]     base_up;
  } qry_t;

endpackage

// ----- sv/gne_if.sv -----
// request and response channel interfaces (valid/ready with payload)
// depends on gne_pkg
interface gne_req_if;
  import gne_pkg::*;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] cell_x;
  logic [7:0] cell_y;
  logic       wall_value;

  modport source (output valid, opcode, cell_x, cell_y, wall_value, input ready);
  modport sink   (input valid, opcode, cell_x, cell_y, wall_value, output ready);
endinterface

interface gne_rsp_if;
  import gne_pkg::*;
  logic             valid;
  logic             ready;
  logic             neighbour_valid;
  logic [IDX_W-1:0] neighbour_index;
  logic             is_diagonal;
  logic             last;

  modport source (output valid, neighbour_valid, neighbour_index, is_diagonal, last,
                  input ready);
  modport sink   (input valid, neighbour_valid, neighbour_index, is_diagonal, last,
                  output ready);
endinterface

// ----- sv/gne_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module gne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/gne_cfg.sv -----
// map size registers with clamping to the storage range
// depends on gne_pkg
module gne_cfg #(
  parameter int MAX_DIM = 256,
  localparam int DIM_W = ($clog2(MAX_DIM + 1) > 9) ? $clog2(MAX_DIM + 1) : 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [gne_pkg::CFG_W-1:0] cfg_data,
  output logic [DIM_W-1:0]          dim_w,
  output logic [DIM_W-1:0]          dim_h
);
  import gne_pkg::*;

  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= CFG_W'(256);
      map_height <= CFG_W'(256);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width  <= cfg_data;
        CFG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] ve;
    ve = DIM_W'(v);
    if (v == '0) return DIM_W'(1);
    if (ve > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return ve;
  endfunction

  // zero reads as one, oversize reads as the storage limit
  assign dim_w = clamp_dim(map_width);
  assign dim_h = clamp_dim(map_height);

endmodule

// ----- sv/gne_seq.sv -----
// item sequencer: map clearing, wall writes by row read-modify-write,
// and the three row reads that build a query's 3x3 window and neighbour mask
// depends on gne_pkg, gne_if
module gne_seq #(
  parameter int MAX_DIM = 256,
  localparam int AW    = $clog2(MAX_DIM),
  localparam int DIM_W = ($clog2(MAX_DIM + 1) > 9) ? $clog2(MAX_DIM + 1) : 9
) (
  input  logic               clk,
  input  logic               rst,
  gne_req_if.sink            req,
  input  logic [DIM_W-1:0]   dim_w,
  input  logic [DIM_W-1:0]   dim_h,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [MAX_DIM-1:0] ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  logic [MAX_DIM-1:0] ram_rdata,
  input  logic               emit_busy,
  output logic               start,
  output gne_pkg::qry_t      ctx
);
  import gne_pkg::*;

  localparam int IW = (AW > 9) ? AW : 9;
  localparam int PW = 8 + DIM_W;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WR_RD = 4'd2;
  localparam logic [3:0] ST_WR_WB = 4'd3;
  localparam logic [3:0] ST_Q_CTR = 4'd4;
  localparam logic [3:0] ST_Q_UP  = 4'd5;
  localparam logic [3:0] ST_Q_DN  = 4'd6;
  localparam logic [3:0] ST_Q_FIN = 4'd7;
  localparam logic [3:0] ST_Q_GO  = 4'd8;

  logic [3:0]       state;
  logic [AW-1:0]    clr_cnt;
  logic [7:0]       cx;
  logic [7:0]       cy;
  logic             wv;
  logic             inmap;
  logic             lf_ok, rt_ok, dn_ok, up_ok;
  logic [2:0]       win_up, win_ctr, win_dn;
  logic [IDX_W-1:0] base_ctr, base_up, base_dn;
  logic [PW-1:0]    row_prod;
  logic [IW-1:0]    cy_i, cx_i;
  logic [NBR_COUNT-1:0] mask;
  logic             accept;

  // three wall bits around column x, out-of-storage columns read open
  function automatic logic [2:0] row_bits(input logic [MAX_DIM-1:0] row,
                                          input logic [7:0] x);
    logic [IW-1:0] xl, xm, xr;
    logic [2:0]    b;
    xm = IW'(x);
    xl = xm - IW'(1);
    xr = xm + IW'(1);
    b[COL_L] = (int'(xl) < MAX_DIM) ? row[xl[AW-1:0]] : 1'b0;
    b[COL_M] = (int'(xm) < MAX_DIM) ? row[xm[AW-1:0]] : 1'b0;
    b[COL_R] = (int'(xr) < MAX_DIM) ? row[xr[AW-1:0]] : 1'b0;
    return b;
  endfunction

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign cy_i      = IW'(cy);
  assign cx_i      = IW'(cx);
  assign row_prod  = PW'(cy) * PW'(dim_w);

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cy_i[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = cy_i[AW-1:0];
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      ST_WR_WB: begin
        ram_we = 1'b1;
        ram_wdata[cx_i[AW-1:0]] = wv;
      end
      ST_Q_UP: ram_raddr = cy_i[AW-1:0] + AW'(1);
      ST_Q_DN: ram_raddr = cy_i[AW-1:0] - AW'(1);
      default: ;
    endcase
  end

  // passable neighbours, diagonals also need both flanking straight cells open
  always_comb begin
    mask[0] = up_ok & ~win_up[COL_M];
    mask[1] = rt_ok & ~win_ctr[COL_R];
    mask[2] = dn_ok & ~win_dn[COL_M];
    mask[3] = lf_ok & ~win_ctr[COL_L];
    mask[4] = up_ok & lf_ok & ~(win_up[COL_L] | win_up[COL_M] | win_ctr[COL_L]);
    mask[5] = up_ok & rt_ok & ~(win_up[COL_R] | win_up[COL_M] | win_ctr[COL_R]);
    mask[6] = dn_ok & rt_ok & ~(win_dn[COL_R] | win_dn[COL_M] | win_ctr[COL_R]);
    mask[7] = dn_ok & lf_ok & ~(win_dn[COL_L] | win_dn[COL_M] | win_ctr[COL_L]);
    if (!inmap) begin
      mask = '0;
    end
  end

  assign start        = (state == ST_Q_GO) && !emit_busy;
  assign ctx.mask     = mask;
  assign ctx.cx       = cx;
  assign ctx.base_dn  = base_dn;
  assign ctx.base_ctr = base_ctr;
  assign ctx.base_up  = base_up;

  // item latch and bounds flags
  always_ff @(posedge clk) begin
    if (accept) begin
      cx    <= req.cell_x;
      cy    <= req.cell_y;
      wv    <= req.wall_value;
      inmap <= (DIM_W'(req.cell_x) < dim_w) && (DIM_W'(req.cell_y) < dim_h);
      lf_ok <= (req.cell_x != 8'd0);
      dn_ok <= (req.cell_y != 8'd0);
      rt_ok <= (DIM_W'(req.cell_x) + DIM_W'(1)) < dim_w;
      up_ok <= (DIM_W'(req.cell_y) + DIM_W'(1)) < dim_h;
    end
    case (state)
      ST_Q_CTR: base_ctr <= row_prod[IDX_W-1:0];
      ST_Q_UP: begin
        win_ctr <= row_bits(ram_rdata, cx);
        base_up <= base_ctr + IDX_W'(dim_w);
      end
      ST_Q_DN: begin
        win_up  <= row_bits(ram_rdata, cx);
        base_dn <= base_ctr - IDX_W'(dim_w);
      end
      ST_Q_FIN: win_dn <= row_bits(ram_rdata, cx);
      default: ;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(MAX_DIM - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (req.opcode == OP_WRITE) begin
              if ((int'(req.cell_x) < MAX_DIM) && (int'(req.cell_y) < MAX_DIM)) begin
                state <= ST_WR_RD;
              end
            end else if ((DIM_W'(req.cell_x) < dim_w) && (DIM_W'(req.cell_y) < dim_h)) begin
              state <= ST_Q_CTR;
            end else begin
              state <= ST_Q_GO;
            end
          end
        end
        ST_WR_RD: state <= ST_WR_WB;
        ST_WR_WB: state <= ST_IDLE;
        ST_Q_CTR: state <= ST_Q_UP;
        ST_Q_UP:  state <= ST_Q_DN;
        ST_Q_DN:  state <= ST_Q_FIN;
        ST_Q_FIN: state <= ST_Q_GO;
        ST_Q_GO: begin
          if (!emit_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/gne_emit.sv -----
// result stage: walks a query's neighbour mask in visiting order and drives
// one beat per passable neighbour (one empty beat if none) from an output register
// depends on gne_pkg, gne_if
module gne_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gne_pkg::qry_t ctx,
  output logic          busy,
  gne_rsp_if.source     rsp
);
  import gne_pkg::*;

  qry_t                 cur;
  logic [NBR_COUNT-1:0] rest;
  logic [2:0]           pick;
  logic                 load;
  logic [IDX_W-1:0]     base_sel;
  logic [IDX_W-1:0]     nx;
  logic                 out_valid;
  logic                 out_nv;
  logic [IDX_W-1:0]     out_idx;
  logic                 out_diag;
  logic                 out_last;

  // first remaining neighbour
  always_comb begin
    pick = 3'd0;
    for (int i = NBR_COUNT - 1; i >= 0; i--) begin
      if (cur.mask[i]) begin
        pick = 3'(i);
      end
    end
    rest = cur.mask & ~(NBR_COUNT'(1) << pick);
  end

  // flattened index of the picked neighbour
  always_comb begin
    case (NBR_ROW[pick])
      ROW_UP:  base_sel = cur.base_up;
      ROW_DN:  base_sel = cur.base_dn;
      default: base_sel = cur.base_ctr;
    endcase
    case (NBR_COL[pick])
      COL_L:   nx = IDX_W'(cur.cx) - IDX_W'(1);
      COL_R:   nx = IDX_W'(cur.cx) + IDX_W'(1);
      default: nx = IDX_W'(cur.cx);
    endcase
  end

  assign load = busy && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // output register: refill on load, empty once the beat is taken
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        busy <= 1'b1;
        cur  <= ctx;
      end else if (load) begin
        if (cur.mask == '0) begin
          // nothing passable: one empty closing beat
          out_nv   <= 1'b0;
          out_idx  <= '0;
          out_diag <= 1'b0;
          out_last <= 1'b1;
          busy     <= 1'b0;
        end else begin
          out_nv   <= 1'b1;
          out_idx  <= base_sel + nx;
          out_diag <= pick[2];
          out_last <= (rest == '0);
          cur.mask <= rest;
          if (rest == '0) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.neighbour_valid = out_nv;
  assign rsp.neighbour_index = out_idx;
  assign rsp.is_diagonal     = out_diag;
  assign rsp.last            = out_last;

endmodule

// ----- sv/grid_neighbour_expander_unit.sv -----
// Grid neighbour expander: keeps a one-bit wall map and lists the passable
// eight-connected neighbours of a queried cell.
// Channels: req carries write beats (opcode 0: set the wall mark of cell_x,
// cell_y to wall_value, no result) and query beats (opcode 1). rsp carries one
// beat per passable neighbour in the order +y, +x, -y, -x, then the diagonals,
// with neighbour_index = y*width+x; the final beat has last set. A query of a
// cell outside the map, or one with no passable neighbour, gives one empty beat.
// The map lives in a row-wide ram (one row per y), so a write is a row
// read-modify-write. A query reads three rows, then its mask goes to the
// result stage, which registers one beat per cycle while the receiver keeps
// ready high; a cell outside the map skips the row reads. A new query waits
// while the previous one still has results to send; writes proceed meanwhile.
// If the receiver stalls, the output register holds its beat and the walk
// pauses.
// Reset: map_width and map_height return to 256 and the map is cleared
// row by row, during which req.ready is low; configuration writes are
// taken at any time.
// depends on gne_pkg, gne_if, gne_ram, gne_cfg, gne_seq, gne_emit
module grid_neighbour_expander_unit #(
  parameter int MAX_DIM = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  gne_req_if.sink                   req,
  gne_rsp_if.source                 rsp,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [gne_pkg::CFG_W-1:0] cfg_data
);
  import gne_pkg::*;

  localparam int AW    = $clog2(MAX_DIM);
  localparam int DIM_W = ($clog2(MAX_DIM + 1) > 9) ? $clog2(MAX_DIM + 1) : 9;

  logic [DIM_W-1:0]   dim_w;
  logic [DIM_W-1:0]   dim_h;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [MAX_DIM-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [MAX_DIM-1:0] ram_rdata;
  logic               emit_busy;
  logic               start;
  qry_t               ctx;

  gne_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dim_w     (dim_w),
    .dim_h     (dim_h)
  );

  gne_ram #(.WIDTH(MAX_DIM), .DEPTH(MAX_DIM)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gne_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .dim_w     (dim_w),
    .dim_h     (dim_h),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .emit_busy (emit_busy),
    .start     (start),
    .ctx       (ctx)
  );

  gne_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ctx   (ctx),
    .busy  (emit_busy),
    .rsp   (rsp)
  );

endmodule

// ----- dv/gne_neighbour_checker.sv -----
// beat checker for the grid neighbour expander: keeps its own wall marks and map size,
// lists the expected neighbour beats of each query and compares the response channel
// depends on gne_pkg and gne_if
module gne_neighbour_checker (
  input  logic                      clk,
  input  logic                      rst,
  gne_req_if                        req,
  gne_rsp_if                        rsp,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [gne_pkg::CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);
  import gne_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_DIM = 256;

  typedef struct packed {
    logic             nv;
    logic [IDX_W-1:0] idx;
    logic             diag;
    logic             last;
  } nbr_beat_t;

  bit               wall_marks [0:GRID_DIM*GRID_DIM-1];
  logic [CFG_W-1:0] map_w;
  logic [CFG_W-1:0] map_h;
  nbr_beat_t        pending_beats [$];

  // register value as the block uses it: zero counts as one, cap at grid size
  function automatic int used_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_DIM) return GRID_DIM;
    return int'(v);
  endfunction

  function automatic bit wall_at(input int x, input int y);
    return wall_marks[y * GRID_DIM + x];
  endfunction

  // expected beats of one query, in visiting order
  function automatic void expand_neighbours(input logic [7:0] cx, input logic [7:0] cy);
    int        w, h, x0, y0, nx, ny, dx, dy, hits;
    nbr_beat_t found [NBR_COUNT];
    nbr_beat_t beat;
    w = used_dim(map_w);
    h = used_dim(map_h);
    x0 = int'(cx);
    y0 = int'(cy);
    hits = 0;
    if (x0 < w && y0 < h) begin
      for (int i = 0; i < NBR_COUNT; i++) begin
        case (i)
          0: begin dx = 0;  dy = 1;  end
          1: begin dx = 1;  dy = 0;  end
          2: begin dx = 0;  dy = -1; end
          3: begin dx = -1; dy = 0;  end
          4: begin dx = -1; dy = 1;  end
          5: begin dx = 1;  dy = 1;  end
          6: begin dx = 1;  dy = -1; end
          default: begin dx = -1; dy = -1; end
        endcase
        nx = x0 + dx;
        ny = y0 + dy;
        if (nx < 0 || nx >= w || ny < 0 || ny >= h) continue;
        if (wall_at(nx, ny)) continue;
        // no corner cutting past a wall on either side
        if (i > 3 && (wall_at(nx, y0) || wall_at(x0, ny))) continue;
        beat.nv   = 1'b1;
        beat.idx  = IDX_W'(ny * w + nx);
        beat.diag = (i > 3);
        beat.last = 1'b0;
        found[hits] = beat;
        hits++;
      end
    end
    // outside the map or nothing passable: one empty closing beat
    if (hits == 0) begin
      beat = '0;
      beat.last = 1'b1;
      pending_beats.push_back(beat);
    end else begin
      for (int k = 0; k < hits; k++) begin
        beat = found[k];
        beat.last = (k == hits - 1);
        pending_beats.push_back(beat);
      end
    end
  endfunction

  always @(posedge clk) begin
    nbr_beat_t want, seen;
    if (rst) begin
      for (int a = 0; a < GRID_DIM * GRID_DIM; a++) wall_marks[a] = 1'b0;
      map_w = 9'd256;
      map_h = 9'd256;
      pending_beats.delete();
      fail_count = 0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        if (cfg_index == CFG_MAP_WIDTH) map_w = cfg_data;
        else map_h = cfg_data;
      end
      // response beats against the oldest expectation
      if (rsp.valid && rsp.ready) begin
        seen.nv   = rsp.neighbour_valid;
        seen.idx  = rsp.neighbour_index;
        seen.diag = rsp.is_diagonal;
        seen.last = rsp.last;
        if (pending_beats.size() == 0) begin
          if (fail_count < 10)
            $display("%0t checker: beat with nothing expected nv=%0d idx=%0d diag=%0d last=%0d",
                     $realtime, seen.nv, seen.idx, seen.diag, seen.last);
          fail_count++;
        end else begin
          want = pending_beats.pop_front();
          if (seen !== want) begin
            if (fail_count < 10)
              $display({"%0t checker: beat mismatch exp nv=%0d idx=%0d diag=%0d last=%0d",
                        " got nv=%0d idx=%0d diag=%0d last=%0d"},
                       $realtime, want.nv, want.idx, want.diag, want.last,
                       seen.nv, seen.idx, seen.diag, seen.last);
            fail_count++;
          end
        end
      end
      // request beats: writes update the marks, queries add expectations
      if (req.valid && req.ready) begin
        if (req.opcode == OP_WRITE)
          wall_marks[int'(req.cell_y) * GRID_DIM + int'(req.cell_x)] = req.wall_value;
        else
          expand_neighbours(req.cell_x, req.cell_y);
      end
    end
    pending = pending_beats.size();
  end

endmodule

// ----- dv/grid_neighbour_expander_unit_tb.sv -----
// testbench top for grid_neighbour_expander_unit: clock, reset, request and register
// stimulus, a randomly stalling receiver and the verdict; checking is in gne_neighbour_checker
// depends on gne_pkg, gne_if, gne_neighbour_checker and the block
module grid_neighbour_expander_unit_tb;
  import gne_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE      = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 16;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fails;
  int               pending;
  bit               pressure_go = 1'b0;

  gne_req_if req ();
  gne_rsp_if rsp ();

  grid_neighbour_expander_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gne_neighbour_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fails),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int used_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  // window centre: map edge, far edge or anywhere inside
  function automatic int pick_base(input int lim);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return lim - 1;
      default: return $urandom_range(0, lim - 1);
    endcase
  endfunction

  function automatic logic [7:0] pick_coord(input int base);
    int c;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    c = base + $urandom_range(0, 6) - 3;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return 8'(c);
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0:       return 9'd1;
      1:       return 9'd2;
      2:       return 9'($urandom_range(3, 16));
      3:       return 9'd256;
      4:       return 9'd0;
      5:       return 9'($urandom_range(257, 511));
      6:       return 9'($urandom_range(1, 511));
      default: return 9'd255;
    endcase
  endfunction

  // one request beat; called and returns at a rising edge
  task automatic send_item(input logic op, input logic [7:0] x, input logic [7:0] y,
                           input logic wv, input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.opcode     <= op;
    req.cell_x     <= x;
    req.cell_y     <= y;
    req.wall_value <= wv;
    @(negedge clk);
    while (!req.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // stop offering, wait for every expected beat, then let trailing writes finish
  task automatic drain_and_settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_map_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: random stalls, bursts of full rate and one long hold-off
  initial begin : rsp_drain
    bit held;
    int run, stall;
    held = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (pressure_go && !held) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      rsp.ready <= 1'b1;
      for (int k = 0; k < run && !(pressure_go && !held); k++) @(posedge clk);
      stall = gap_len();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        for (int k = 0; k < stall && !(pressure_go && !held); k++) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_W-1:0] w, h;
    logic             op, wv;
    logic [7:0]       x, y;
    int               bx, by;
    bit               no_gaps;
    req.valid      <= 1'b0;
    req.opcode     <= OP_WRITE;
    req.cell_x     <= 8'd0;
    req.cell_y     <= 8'd0;
    req.wall_value <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= CFG_MAP_WIDTH;
    cfg_data       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // full-size map after reset: corners, blocked straights, blocked diagonals
    send_item(OP_QUERY, 8'd0,   8'd0,   1'b0, 1'b0);
    send_item(OP_QUERY, 8'd255, 8'd255, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'd10,  8'd11,  1'b1, 1'b0);
    send_item(OP_QUERY, 8'd10,  8'd10,  1'b0, 1'b0);
    send_item(OP_WRITE, 8'd11,  8'd9,   1'b1, 1'b0);
    send_item(OP_QUERY, 8'd10,  8'd10,  1'b0, 1'b0);
    // walled in on all four sides: single empty beat
    send_item(OP_WRITE, 8'd50,  8'd51,  1'b1, 1'b0);
    send_item(OP_WRITE, 8'd51,  8'd50,  1'b1, 1'b0);
    send_item(OP_WRITE, 8'd50,  8'd49,  1'b1, 1'b0);
    send_item(OP_WRITE, 8'd49,  8'd50,  1'b1, 1'b0);
    send_item(OP_QUERY, 8'd50,  8'd50,  1'b0, 1'b0);
    send_item(OP_WRITE, 8'd10,  8'd11,  1'b0, 1'b0);
    send_item(OP_QUERY, 8'd10,  8'd10,  1'b0, 1'b0);
    send_item(OP_WRITE, 8'd255, 8'd255, 1'b1, 1'b0);
    send_item(OP_QUERY, 8'd254, 8'd254, 1'b0, 1'b0);
    send_item(OP_QUERY, 8'd255, 8'd255, 1'b0, 1'b0);
    drain_and_settle();

    // one-cell map: no neighbours, query outside, write outside the map kept
    set_map_size(9'd1, 9'd1);
    send_item(OP_QUERY, 8'd0, 8'd0, 1'b0, 1'b0);
    send_item(OP_QUERY, 8'd1, 8'd0, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd3, 8'd0, 1'b1, 1'b0);
    drain_and_settle();

    // zero width counts as one, oversize height as full
    set_map_size(9'd0, 9'd511);
    send_item(OP_QUERY, 8'd0, 8'd5, 1'b0, 1'b0);
    send_item(OP_QUERY, 8'd0, 8'd0, 1'b0, 1'b0);
    drain_and_settle();

    // single row; earlier mark at (3,0) now inside the map
    set_map_size(9'd300, 9'd0);
    send_item(OP_QUERY, 8'd3, 8'd0, 1'b0, 1'b0);
    send_item(OP_QUERY, 8'd2, 8'd0, 1'b0, 1'b0);
    drain_and_settle();

    // random phases: local clusters of writes and queries around a chosen spot
    for (int p = 0; p < NUM_PHASES; p++) begin
      w = pick_dim();
      h = pick_dim();
      set_map_size(w, h);
      bx = pick_base(used_dim(w));
      by = pick_base(used_dim(h));
      no_gaps = ($urandom_range(0, 3) == 0);
      if (p == 0) pressure_go = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_QUERY;
        x  = pick_coord(bx);
        y  = pick_coord(by);
        wv = ($urandom_range(0, 2) != 0);
        send_item(op, x, y, wv, no_gaps);
      end
      drain_and_settle();
    end

    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/gne_pkg.sv
sv/gne_if.sv
sv/gne_ram.sv
sv/gne_cfg.sv
sv/gne_seq.sv
sv/gne_emit.sv
sv/grid_neighbour_expander_unit.sv
dv/gne_neighbour_checker.sv
dv/grid_neighbour_expander_unit_tb.sv
